[rtl/nmf_pkg.sv]
// Shared constants, types and helpers for the neighbourhood mean filter.
package nmf_pkg;

    localparam int MAX_RADIUS = 7;
    localparam int MAX_WIDTH  = 1024;
    localparam int LINE_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int LINE_DEPTH = LINE_ROWS * MAX_WIDTH;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int SLOT_W     = $clog2(LINE_ROWS);
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int ROW_W      = 16;
    localparam int WIDTH_W    = 11;
    localparam int WIN_W      = $clog2(2 * MAX_RADIUS + 1);
    localparam int SUM_W      = 16;
    localparam int CNT_W      = 8;
    localparam int REM_W      = SUM_W + 1;
    localparam int DEN_W      = CNT_W + 1;

    // Neighbourhood shapes
    localparam logic [2:0] MODE_HORIZ  = 3'd0;
    localparam logic [2:0] MODE_VERT   = 3'd1;
    localparam logic [2:0] MODE_CROSS  = 3'd2;
    localparam logic [2:0] MODE_DIAG   = 3'd3;
    localparam logic [2:0] MODE_RING   = 3'd4;
    localparam logic [2:0] MODE_SQUARE = 3'd5;

    // Register indexes on the APB port
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DINIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic scan_last;
        logic div_last;
    } status_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [2:0]         radius;
        logic [WIDTH_W-1:0] width;
        logic [ROW_W-1:0]   height;
    } cfg_t;

    // Is window position (k, j) part of the neighbourhood? Centre sits at (rad, rad).
    function automatic logic in_shape(input logic [2:0] mode, input logic [WIN_W-1:0] k,
                                      input logic [WIN_W-1:0] j, input logic [2:0] rad);
        logic dr0;
        logic dc0;
        logic [WIN_W:0] ksum;
        logic res;
        dr0  = (k == {1'b0, rad});
        dc0  = (j == {1'b0, rad});
        ksum = {1'b0, k} + {1'b0, j};
        case (mode)
            MODE_HORIZ: res = dr0 && !dc0;
            MODE_VERT:  res = dc0 && !dr0;
            MODE_CROSS: res = dr0 ^ dc0;
            MODE_DIAG:  res = !dr0 && ((k == j) || (ksum == {1'b0, rad, 1'b0}));
            MODE_RING:  res = !(dr0 && dc0);
            default:    res = 1'b1;
        endcase
        return res;
    endfunction

endpackage

[rtl/nmf_ctrl.sv]
// Sequencer: accepts a pixel, scans the window, runs the divider, presents the result.
module nmf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  nmf_pkg::status_t status,
    output nmf_pkg::cmd_t    cmd
);
    import nmf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_full_reg;
    logic   out_full_next;

    // State register and output slot flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = out_full_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                if (in_valid && status.emit)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Move the mean into the output slot once it is free
                if (!out_full_reg || !out_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Output slot: emptied by the receiver, filled by a load
        out_full_next = out_full_reg;
        if (out_full_reg && !out_stall)
        begin
            out_full_next = 1'b0;
        end
        if (cmd.load)
        begin
            out_full_next = 1'b1;
        end
    end

endmodule

[rtl/nmf_datapath.sv]
// Line store, raster position, window accumulator and mean divider.
module nmf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  nmf_pkg::cmd_t                 cmd,
    output nmf_pkg::status_t              status,
    input  nmf_pkg::cfg_t                 cfg,
    input  logic [7:0]                    pixel,
    input  logic                          frame_start,
    output logic [7:0]                    mean_value,
    output logic [nmf_pkg::ROW_W-1:0]     centre_row,
    output logic [nmf_pkg::COL_W-1:0]     centre_col,
    output logic                          frame_last
);
    import nmf_pkg::*;

    logic [7:0] line_mem [0:LINE_DEPTH-1];

    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [SLOT_W-1:0]  wslot_reg;
    logic [2:0]         use_mode_reg;
    logic [2:0]         use_rad_reg;
    logic [WIDTH_W-1:0] use_width_reg;
    logic [ROW_W-1:0]   use_height_reg;

    logic [WIN_W-1:0]   k_reg;
    logic [WIN_W-1:0]   j_reg;
    logic [SLOT_W-1:0]  rslot_reg;
    logic [COL_W-1:0]   cbase_reg;
    logic               sel_d1_reg;
    logic               acc_d1_reg;
    logic [7:0]         rd_data_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [2:0]         bit_reg;
    logic [7:0]         q_reg;
    logic [ROW_W-1:0]   crow_reg;
    logic [COL_W-1:0]   ccol_reg;
    logic               flast_reg;
    logic [7:0]         mean_out_reg;
    logic [ROW_W-1:0]   row_out_reg;
    logic [COL_W-1:0]   col_out_reg;
    logic               last_out_reg;

    logic               sample;
    logic [ROW_W-1:0]   cur_r;
    logic [COL_W-1:0]   cur_c;
    logic [SLOT_W-1:0]  cur_slot;
    logic [2:0]         san_mode;
    logic [2:0]         san_rad;
    logic [WIDTH_W-1:0] san_width;
    logic [ROW_W-1:0]   san_height;
    logic [2:0]         eff_mode;
    logic [2:0]         eff_rad;
    logic [WIDTH_W-1:0] eff_width;
    logic [ROW_W-1:0]   eff_height;
    logic [WIN_W-1:0]   eff_rad2;
    logic [WIN_W-1:0]   use_rad2;
    logic               col_end;
    logic               row_end;
    logic [SLOT_W:0]    slot_diff;
    logic [SLOT_W-1:0]  start_slot;
    logic [REM_W-1:0]   trial;

    // Register sanitising, sampled at the first pixel of a frame
    always_comb
    begin
        san_mode   = (cfg.mode > MODE_SQUARE) ? MODE_SQUARE : cfg.mode;
        san_rad    = (cfg.radius == 3'd0) ? 3'd1 : cfg.radius;
        san_width  = (cfg.width < WIDTH_W'(3)) ? WIDTH_W'(3) :
                     ((cfg.width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : cfg.width);
        san_height = (cfg.height < ROW_W'(3)) ? ROW_W'(3) : cfg.height;
    end

    // Position of the incoming pixel and the settings that apply to it
    always_comb
    begin
        sample     = frame_start || ((row_reg == '0) && (col_reg == '0));
        cur_r      = frame_start ? '0 : row_reg;
        cur_c      = frame_start ? '0 : col_reg;
        cur_slot   = frame_start ? '0 : wslot_reg;
        eff_mode   = sample ? san_mode : use_mode_reg;
        eff_rad    = sample ? san_rad : use_rad_reg;
        eff_width  = sample ? san_width : use_width_reg;
        eff_height = sample ? san_height : use_height_reg;
        eff_rad2   = {eff_rad, 1'b0};
        use_rad2   = {use_rad_reg, 1'b0};
        col_end    = ({1'b0, cur_c} + WIDTH_W'(1)) >= eff_width;
        row_end    = ({1'b0, cur_r} + (ROW_W+1)'(1)) >= {1'b0, eff_height};
        status.emit = (cur_r >= ROW_W'(eff_rad2)) && (cur_c >= COL_W'(eff_rad2));
        slot_diff  = {1'b0, cur_slot} + (SLOT_W+1)'(LINE_ROWS) - (SLOT_W+1)'(eff_rad2);
        start_slot = (slot_diff >= (SLOT_W+1)'(LINE_ROWS)) ?
                     SLOT_W'(slot_diff - (SLOT_W+1)'(LINE_ROWS)) : slot_diff[SLOT_W-1:0];
        status.scan_last = (k_reg == use_rad2) && (j_reg == use_rad2);
        status.div_last  = (bit_reg == 3'd0);
        trial = REM_W'(den_reg) << bit_reg;
    end

    // Raster position and sampled settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            wslot_reg      <= '0;
            use_mode_reg   <= MODE_SQUARE;
            use_rad_reg    <= 3'd1;
            use_width_reg  <= WIDTH_W'(MAX_WIDTH);
            use_height_reg <= ROW_W'(1024);
        end
        else if (cmd.take)
        begin
            use_mode_reg   <= eff_mode;
            use_rad_reg    <= eff_rad;
            use_width_reg  <= eff_width;
            use_height_reg <= eff_height;
            if (col_end)
            begin
                col_reg <= '0;
                if (row_end)
                begin
                    row_reg   <= '0;
                    wslot_reg <= '0;
                end
                else
                begin
                    row_reg   <= cur_r + ROW_W'(1);
                    wslot_reg <= (cur_slot == SLOT_W'(LINE_ROWS - 1)) ? '0 :
                                 cur_slot + SLOT_W'(1);
                end
            end
            else
            begin
                col_reg   <= cur_c + COL_W'(1);
                row_reg   <= cur_r;
                wslot_reg <= cur_slot;
            end
        end
    end

    // Line store: write on accept, read while scanning
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            line_mem[ADDR_W'({cur_slot, cur_c})] <= pixel;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= line_mem[ADDR_W'({rslot_reg, cbase_reg + COL_W'(j_reg)})];
        end
    end

    // Window walk, accumulation and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_d1_reg <= 1'b0;
        end
        else
        begin
            acc_d1_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_d1_reg <= in_shape(use_mode_reg, k_reg, j_reg, use_rad_reg);
        if (cmd.take)
        begin
            k_reg     <= '0;
            j_reg     <= '0;
            rslot_reg <= start_slot;
            cbase_reg <= cur_c - COL_W'(eff_rad2);
            sum_reg   <= '0;
            cnt_reg   <= '0;
            crow_reg  <= cur_r - ROW_W'(eff_rad);
            ccol_reg  <= cur_c - COL_W'(eff_rad);
            flast_reg <= row_end && col_end;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                if (j_reg == use_rad2)
                begin
                    j_reg     <= '0;
                    k_reg     <= k_reg + WIN_W'(1);
                    rslot_reg <= (rslot_reg == SLOT_W'(LINE_ROWS - 1)) ? '0 :
                                 rslot_reg + SLOT_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + WIN_W'(1);
                end
            end
            if (acc_d1_reg && sel_d1_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        // Rounded mean: (2*sum + count) / (2*count), one quotient bit a cycle
        if (cmd.div_init)
        begin
            rem_reg <= {sum_reg, 1'b0} + REM_W'(cnt_reg);
            den_reg <= {cnt_reg, 1'b0};
            bit_reg <= 3'd7;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg        <= rem_reg - trial;
                q_reg[bit_reg] <= 1'b1;
            end
            bit_reg <= bit_reg - 3'd1;
        end
    end

    // Output slot, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mean_out_reg <= q_reg;
            row_out_reg  <= crow_reg;
            col_out_reg  <= ccol_reg;
            last_out_reg <= flast_reg;
        end
    end

    assign mean_value = mean_out_reg;
    assign centre_row = row_out_reg;
    assign centre_col = col_out_reg;
    assign frame_last = last_out_reg;

endmodule

[rtl/neighborhood_mean_filter.sv]
// Neighbourhood mean filter: top level with APB register bank.
//
// Input channel: pixel and frame_start, a request accepted when in_valid is
// high and in_stall low. Pixels come in raster order; frame_start puts the
// pixel at row 0, column 0. Registers (mode, radius, frame_width,
// frame_height at byte addresses 0, 4, 8, 12) are sampled at the first pixel
// of each frame.
// Output channel: mean_value, centre_row, centre_col and frame_last, one
// request per interior centre, held in an output slot while out_stall is high.
// A pixel that yields no result leaves the sequencer idle and ready for the
// next pixel. A pixel that yields a result is followed by the window scan
// of (2R+1)^2 positions (one line store read a cycle), a drain state, the
// divider set-up, the bit-serial divide and the load of the output slot, so
// the result is offered and the next pixel taken once the sequencer is idle
// again; the single-port line store and the bit-serial divider set this pace.
// While the receiver stalls, the result waits in the slot and pixels are still
// taken; a second result waits in the sequencer with in_stall high.
// Reset clears position and sets mode 5, radius 1, 1024 x 1024; the line
// store needs no clearing since only pixels of the current frame are read.
module neighborhood_mean_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  mean_value,
    output logic [15:0] centre_row,
    output logic [9:0]  centre_col,
    output logic        frame_last
);
    import nmf_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    // Register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_SQUARE;
            cfg_reg.radius <= 3'd1;
            cfg_reg.width  <= WIDTH_W'(1024);
            cfg_reg.height <= ROW_W'(1024);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_MODE:   cfg_reg.mode   <= pwdata[2:0];
                REG_RADIUS: cfg_reg.radius <= pwdata[2:0];
                REG_WIDTH:  cfg_reg.width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: cfg_reg.height <= pwdata[ROW_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = {29'd0, cfg_reg.mode};
            REG_RADIUS: prdata = {29'd0, cfg_reg.radius};
            REG_WIDTH:  prdata = {21'd0, cfg_reg.width};
            REG_HEIGHT: prdata = {16'd0, cfg_reg.height};
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    nmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nmf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg         (cfg_reg),
        .pixel       (pixel),
        .frame_start (frame_start),
        .mean_value  (mean_value),
        .centre_row  (centre_row),
        .centre_col  (centre_col),
        .frame_last  (frame_last)
    );

endmodule

[rtl/nmf_checker.sv]
// Port-level checks for the neighbourhood mean filter, bound to the top level.
module nmf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  mean_value
);

    // A stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean_value))
        else $error("stalled result changed");

    // Handshake outputs are always driven
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_stall, out_valid}))
        else $error("handshake output unknown");

    // The register port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    // A fresh result only follows a cycle with the input held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while input open");

endmodule

bind neighborhood_mean_filter nmf_checker u_nmf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mean_value (mean_value)
);
